>>> src/lphc_pkg.sv
`timescale 1ns / 1ps
package lphc_pkg;

  localparam int MAX_CAPACITY = 1024;
  localparam int MIN_CAPACITY = 8;
  localparam int ENTRY_SHIFT  = 4;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int HASH_W       = 32;
  localparam int SLOT_W       = $clog2(MAX_CAPACITY);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int LOG_W        = $clog2(SLOT_W + 2);
  localparam int MIN_LOG      = $clog2(MIN_CAPACITY);
  localparam int MAX_LOG      = SLOT_W;
  localparam int EPOCH_W      = 8;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_ERASED   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;
  localparam logic [2:0] ST_RANGE    = 3'd6;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic               vp;
  } entry_t;

  function automatic logic [CNT_W-1:0] cap_of(input logic [LOG_W-1:0] lg);
    cap_of = CNT_W'(1) << lg;
  endfunction

  // (cap + 1) * 7 / 8 for a power of two of at least eight
  function automatic logic [CNT_W-1:0] budget_of(input logic [LOG_W-1:0] lg);
    logic [CNT_W-1:0] c;
    c = cap_of(lg);
    budget_of = c - (c >> 3);
  endfunction

endpackage

>>> src/lphc_ram.sv
`timescale 1ns / 1ps
module lphc_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/linear_probe_hash_cache_unit.sv
`timescale 1ns / 1ps
// Erase, dropped insert and out-of-range read answer from idle; read-slot via S_READ;
// insert probes (one RAM read per probe), after a sweep and S_ISSUE if a clear
// lands on an epoch wrap. One beat in flight: start is taken only while busy is low.
// Reset (rst_n low, synchronous) starts a clearing pass of the slot RAM;
// the same pass runs once every 255 table clears. out_valid lasts one cycle, no stall.
module linear_probe_hash_cache_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_opcode,
  input  logic [lphc_pkg::HASH_W-1:0] in_hash,
  input  logic [lphc_pkg::KEY_W-1:0]  in_key,
  input  logic [lphc_pkg::VAL_W-1:0]  in_value,
  input  logic                        in_value_present,
  input  logic [lphc_pkg::SLOT_W-1:0] in_slot,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [lphc_pkg::SLOT_W-1:0] out_slot_index,
  output logic                        out_occupied,
  output logic [lphc_pkg::KEY_W-1:0]  out_key_out,
  output logic [lphc_pkg::VAL_W-1:0]  out_value_out,
  output logic                        out_value_present_out,
  output logic [lphc_pkg::CNT_W-1:0]  out_capacity_now,
  output logic [lphc_pkg::CNT_W-1:0]  out_used_now
);

  import lphc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [LOG_W-1:0]   lg_r, lg_nxt;
  logic [CNT_W-1:0]   free_r, free_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [SLOT_W-1:0]  sw_r, sw_nxt;
  logic               pend_r, pend_nxt;
  logic [SLOT_W-1:0]  ix_r, ix_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic               vp_r, vp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [SLOT_W-1:0]  sidx_r, sidx_nxt;
  logic               occ_r, occ_nxt;
  logic [KEY_W-1:0]   ko_r, ko_nxt;
  logic [VAL_W-1:0]   vo_r, vo_nxt;
  logic               vpo_r, vpo_nxt;
  logic [CNT_W-1:0]   capo_r, capo_nxt;
  logic [CNT_W-1:0]   usedo_r, usedo_nxt;

  logic               we;
  logic [SLOT_W-1:0]  waddr, raddr;
  entry_t             wentry, rentry;
  logic [$bits(entry_t)-1:0] rdata;

  logic [LOG_W-1:0]   grow_lg, use_lg;
  logic [SLOT_W-1:0]  home, mask_cur, ix_dn;
  logic               hit_valid;

  lphc_ram #(
    .DW($bits(entry_t)),
    .AW(SLOT_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wentry),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rentry    = entry_t'(rdata);
  assign hit_valid = (rentry.tag == epoch_r);
  assign grow_lg   = (used_r == '0) ? lg_r : lg_r + LOG_W'(1);
  assign use_lg    = (free_r == '0) ? grow_lg : lg_r;
  assign home      = in_hash[ENTRY_SHIFT +: SLOT_W] & SLOT_W'(cap_of(use_lg) - CNT_W'(1));
  assign mask_cur  = SLOT_W'(cap_of(lg_r) - CNT_W'(1));
  assign ix_dn     = (ix_r - SLOT_W'(1)) & mask_cur;

  always_comb begin
    state_nxt     = state_r;
    lg_nxt        = lg_r;
    free_nxt      = free_r;
    used_nxt      = used_r;
    epoch_nxt     = epoch_r;
    sw_nxt        = sw_r;
    pend_nxt      = pend_r;
    ix_nxt        = ix_r;
    n_nxt         = n_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    vp_nxt        = vp_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    sidx_nxt      = sidx_r;
    occ_nxt       = occ_r;
    ko_nxt        = ko_r;
    vo_nxt        = vo_r;
    vpo_nxt       = vpo_r;
    capo_nxt      = capo_r;
    usedo_nxt     = usedo_r;
    we            = 1'b0;
    waddr         = ix_r;
    raddr         = ix_r;
    wentry.tag    = epoch_r;
    wentry.key    = key_r;
    wentry.value  = val_r;
    wentry.vp     = vp_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_INSERT: begin
              key_nxt = in_key;
              val_nxt = in_value_present ? in_value : '0;
              vp_nxt  = in_value_present;
              ix_nxt  = home;
              n_nxt   = '0;
              raddr   = home;
              if (free_r == '0 && grow_lg > LOG_W'(MAX_LOG)) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_DROPPED;
                sidx_nxt      = '0;
              end else if (free_r == '0) begin
                lg_nxt   = grow_lg;
                free_nxt = budget_of(grow_lg);
                used_nxt = '0;
                if (epoch_r == EPOCH_LAST) begin
                  pend_nxt  = 1'b1;
                  sw_nxt    = '0;
                  state_nxt = S_SWEEP;
                end else begin
                  epoch_nxt = epoch_r + EPOCH_W'(1);
                  state_nxt = S_PROBE;
                end
              end else begin
                state_nxt = S_PROBE;
              end
            end
            OP_ERASE: begin
              out_valid_nxt = 1'b1;
              sidx_nxt      = '0;
              if (free_r == '0 && used_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                status_nxt = ST_ERASED;
                free_nxt   = '0;
                used_nxt   = '0;
                if (epoch_r == EPOCH_LAST) begin
                  pend_nxt  = 1'b0;
                  sw_nxt    = '0;
                  state_nxt = S_SWEEP;
                end else begin
                  epoch_nxt = epoch_r + EPOCH_W'(1);
                end
              end
            end
            OP_READ: begin
              if ({1'b0, in_slot} >= cap_of(lg_r)) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_RANGE;
                sidx_nxt      = '0;
              end else begin
                ix_nxt    = in_slot;
                raddr     = in_slot;
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        we     = 1'b1;
        waddr  = sw_r;
        wentry = '0;
        sw_nxt = sw_r + SLOT_W'(1);
        if (sw_r == {SLOT_W{1'b1}}) begin
          epoch_nxt = EPOCH_FIRST;
          state_nxt = pend_r ? S_ISSUE : S_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      S_ISSUE: begin
        raddr     = ix_r;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (!hit_valid) begin
          we            = 1'b1;
          free_nxt      = free_r - CNT_W'(1);
          used_nxt      = used_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          status_nxt    = ST_INSERTED;
          sidx_nxt      = ix_r;
          state_nxt     = S_IDLE;
        end else if (rentry.key == key_r) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_PRESENT;
          sidx_nxt      = ix_r;
          state_nxt     = S_IDLE;
        end else if (n_r == cap_of(lg_r) - CNT_W'(1)) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DROPPED;
          sidx_nxt      = '0;
          state_nxt     = S_IDLE;
        end else begin
          ix_nxt = ix_dn;
          raddr  = ix_dn;
          n_nxt  = n_r + CNT_W'(1);
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_READ;
        sidx_nxt      = ix_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_valid_nxt) begin
      capo_nxt  = cap_of(lg_nxt);
      usedo_nxt = used_nxt;
      if (state_r == S_READ && hit_valid) begin
        occ_nxt = 1'b1;
        ko_nxt  = rentry.key;
        vo_nxt  = rentry.value;
        vpo_nxt = rentry.vp;
      end else begin
        occ_nxt = 1'b0;
        ko_nxt  = '0;
        vo_nxt  = '0;
        vpo_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      lg_r        <= LOG_W'(MIN_LOG);
      free_r      <= '0;
      used_r      <= '0;
      epoch_r     <= '0;
      sw_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lg_r        <= lg_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
      epoch_r     <= epoch_nxt;
      sw_r        <= sw_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ix_r     <= ix_nxt;
    n_r      <= n_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    vp_r     <= vp_nxt;
    status_r <= status_nxt;
    sidx_r   <= sidx_nxt;
    occ_r    <= occ_nxt;
    ko_r     <= ko_nxt;
    vo_r     <= vo_nxt;
    vpo_r    <= vpo_nxt;
    capo_r   <= capo_nxt;
    usedo_r  <= usedo_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_slot_index        = sidx_r;
  assign out_occupied          = occ_r;
  assign out_key_out           = ko_r;
  assign out_value_out         = vo_r;
  assign out_value_present_out = vpo_r;
  assign out_capacity_now      = capo_r;
  assign out_used_now          = usedo_r;

  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, used_r} + {1'b0, free_r}) <= {1'b0, cap_of(lg_r)})
    else $error("used plus free budget exceeds capacity");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_PROBE || state_r == S_READ) |-> epoch_r != '0)
    else $error("table live with the sweep epoch");

  a_nop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_NOP) |=> !out_valid)
    else $error("result for an ignored opcode");

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_used_now == used_r && out_capacity_now == cap_of(lg_r)))
    else $error("reported occupancy differs from table state");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import lphc_pkg::*;

  localparam int BEAT_BOUND  = 3000;
  localparam int WORST_BEAT  = 2 * MAX_CAPACITY + 48;
  localparam int CYCLE_LIMIT = 3 * BEAT_BOUND * WORST_BEAT + 4 * MAX_CAPACITY;
  localparam int IDLE_PCT    = 19;
  localparam logic [2:0] NO_REPLY = 3'd7;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic              occupied;
    logic [KEY_W-1:0]  key_out;
    logic [VAL_W-1:0]  value_out;
    logic              vp_out;
    logic [CNT_W-1:0]  capacity_now;
    logic [CNT_W-1:0]  used_now;
  } cache_reply_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  key;
  } key_pair_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [HASH_W-1:0] in_hash;
  logic [KEY_W-1:0]  in_key;
  logic [VAL_W-1:0]  in_value;
  logic              in_value_present;
  logic [SLOT_W-1:0] in_slot;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [SLOT_W-1:0] out_slot_index;
  logic              out_occupied;
  logic [KEY_W-1:0]  out_key_out;
  logic [VAL_W-1:0]  out_value_out;
  logic              out_value_present_out;
  logic [CNT_W-1:0]  out_capacity_now;
  logic [CNT_W-1:0]  out_used_now;

  // shadow copy of the table
  bit               tbl_valid [MAX_CAPACITY];
  logic [KEY_W-1:0] tbl_key   [MAX_CAPACITY];
  logic [VAL_W-1:0] tbl_val   [MAX_CAPACITY];
  logic             tbl_vp    [MAX_CAPACITY];
  int               cap_lg;
  int               budget;
  int               used_cnt;

  cache_reply_t replies_due[$];
  key_pair_t    known_keys[$];
  logic [2:0]   last_status;
  bit           steady;
  int           mismatches;
  int           beats_sent;
  int           replies_checked;
  int           inserts_sent;
  int           reads_sent;
  int           erases_sent;
  int           status_seen [8];
  int unsigned  cycle_count;

  linear_probe_hash_cache_unit DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_hash               (in_hash),
    .in_key                (in_key),
    .in_value              (in_value),
    .in_value_present      (in_value_present),
    .in_slot               (in_slot),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_slot_index        (out_slot_index),
    .out_occupied          (out_occupied),
    .out_key_out           (out_key_out),
    .out_value_out         (out_value_out),
    .out_value_present_out (out_value_present_out),
    .out_capacity_now      (out_capacity_now),
    .out_used_now          (out_used_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached, %0d replies outstanding", $time,
               replies_due.size());
      $display("** linear_probe_hash_cache_unit: FAILED **");
      $finish;
    end
  end

  task automatic reset_shadow();
    foreach (tbl_valid[n]) begin
      tbl_valid[n] = 1'b0;
      tbl_key[n]   = '0;
      tbl_val[n]   = '0;
      tbl_vp[n]    = 1'b0;
    end
    cap_lg   = MIN_LOG;
    budget   = 0;
    used_cnt = 0;
  endtask

  task automatic apply_cache_op(input logic [1:0] op, input logic [HASH_W-1:0] hash,
                                input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
                                input logic vp, input logic [SLOT_W-1:0] slot);
    cache_reply_t r;
    int cap;
    int nl;
    int ix;
    bit done;
    r    = '0;
    done = 1'b0;
    if (op == OP_NOP) begin
      last_status = NO_REPLY;
      return;
    end
    if (op == OP_INSERT) begin
      if (budget == 0) begin
        nl = (used_cnt == 0) ? cap_lg : cap_lg + 1;
        if ((1 << nl) > MAX_CAPACITY) begin
          r.status = ST_DROPPED;
          done     = 1'b1;
        end else begin
          cap_lg = nl;
          foreach (tbl_valid[n]) tbl_valid[n] = 1'b0;
          budget   = ((1 << nl) + 1) * 7 / 8;
          used_cnt = 0;
        end
      end
      if (!done) begin
        cap      = 1 << cap_lg;
        ix       = int'((hash >> ENTRY_SHIFT) & 32'(cap - 1));
        r.status = ST_DROPPED;
        for (int n = 0; n < cap && !done; n++) begin
          if (!tbl_valid[SLOT_W'(ix)]) begin
            tbl_valid[SLOT_W'(ix)] = 1'b1;
            tbl_key[SLOT_W'(ix)]   = key;
            tbl_val[SLOT_W'(ix)]   = vp ? val : '0;
            tbl_vp[SLOT_W'(ix)]    = vp;
            budget--;
            used_cnt++;
            r.status     = ST_INSERTED;
            r.slot_index = SLOT_W'(ix);
            done         = 1'b1;
          end else if (tbl_key[SLOT_W'(ix)] == key) begin
            r.status     = ST_PRESENT;
            r.slot_index = SLOT_W'(ix);
            done         = 1'b1;
          end else begin
            ix = (ix == 0) ? cap - 1 : ix - 1;
          end
        end
      end
    end else if (op == OP_ERASE) begin
      if (budget == 0 && used_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        foreach (tbl_valid[n]) tbl_valid[n] = 1'b0;
        budget   = 0;
        used_cnt = 0;
        r.status = ST_ERASED;
      end
    end else begin
      cap = 1 << cap_lg;
      if (int'(slot) >= cap) begin
        r.status = ST_RANGE;
      end else begin
        r.status     = ST_READ;
        r.slot_index = slot;
        if (tbl_valid[slot]) begin
          r.occupied  = 1'b1;
          r.key_out   = tbl_key[slot];
          r.value_out = tbl_val[slot];
          r.vp_out    = tbl_vp[slot];
        end
      end
    end
    r.capacity_now = CNT_W'(1 << cap_lg);
    r.used_now     = CNT_W'(used_cnt);
    last_status    = r.status;
    replies_due.push_back(r);
  endtask

  task automatic issue_cmd(input logic [1:0] op, input logic [HASH_W-1:0] hash,
                           input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
                           input logic vp, input logic [SLOT_W-1:0] slot);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start            <= 1'b1;
    in_opcode        <= op;
    in_hash          <= hash;
    in_key           <= key;
    in_value         <= val;
    in_value_present <= vp;
    in_slot          <= slot;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    apply_cache_op(op, hash, key, val, vp, slot);
    beats_sent++;
    if (op == OP_INSERT) inserts_sent++;
    if (op == OP_READ) reads_sent++;
    if (op == OP_ERASE) erases_sent++;
    if (op == OP_INSERT && last_status == ST_INSERTED) begin
      known_keys.push_back({hash, key});
      if (known_keys.size() > 64) void'(known_keys.pop_front());
    end
  endtask

  task automatic wait_replies_drained();
    start <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic void cmp_field(input string fname, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cache_reply_t want;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        $display("%0t ns: reply with nothing expected, status %0d", $time, out_status);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        cmp_field("status", 32'(want.status), 32'(out_status));
        cmp_field("slot_index", 32'(want.slot_index), 32'(out_slot_index));
        cmp_field("occupied", 32'(want.occupied), 32'(out_occupied));
        cmp_field("key_out", want.key_out, out_key_out);
        cmp_field("value_out", want.value_out, out_value_out);
        cmp_field("value_present_out", 32'(want.vp_out), 32'(out_value_present_out));
        cmp_field("capacity_now", 32'(want.capacity_now), 32'(out_capacity_now));
        cmp_field("used_now", 32'(want.used_now), 32'(out_used_now));
        status_seen[want.status]++;
        replies_checked++;
      end
    end
  end

  task automatic test_directed_edges();
    issue_cmd(OP_ERASE, '0, '0, '0, 1'b0, '0);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd0);
    issue_cmd(OP_READ, '1, '1, '1, 1'b1, 10'd8);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd1023);
    issue_cmd(OP_INSERT, 32'h0, 32'h0, 32'h0, 1'b1, '0);
    issue_cmd(OP_INSERT, '1, '1, '1, 1'b1, '1);
    // absent value, probes down from slot 0 and wraps
    issue_cmd(OP_INSERT, 32'h0, 32'h1, '1, 1'b0, '0);
    issue_cmd(OP_INSERT, 32'h0, 32'h0, 32'h1234, 1'b1, '0);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd0);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd7);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd6);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd5);
    issue_cmd(OP_NOP, '1, '1, '1, 1'b1, '1);
    issue_cmd(OP_ERASE, '0, '0, '0, 1'b0, '0);
    issue_cmd(OP_ERASE, '0, '0, '0, 1'b0, '0);
    // seven fill the budget, the eighth grows the table
    for (int n = 0; n < 8; n++)
      issue_cmd(OP_INSERT, 32'(n) << ENTRY_SHIFT, 32'h100 + 32'(n), $urandom, 1'b1, '0);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd15);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd16);
  endtask

  task automatic test_random_traffic();
    int counted;
    int roll;
    int cap;
    bit drained;
    logic [HASH_W-1:0] h;
    logic [SLOT_W-1:0] s;
    key_pair_t kp;
    counted = 0;
    drained = 1'b0;
    while (counted < 250) begin
      steady = (counted >= 140 && counted < 220);
      if (counted == 100 && !drained) begin
        wait_replies_drained();
        drained = 1'b1;
      end
      roll = $urandom_range(0, 99);
      cap  = 1 << cap_lg;
      h    = $urandom;
      s    = SLOT_W'($urandom_range(0, 1023));
      if (roll < 48) begin
        if ($urandom_range(0, 99) < 30) h[9:4] = 6'($urandom_range(0, 3));
        issue_cmd(OP_INSERT, h, $urandom, $urandom, 1'($urandom), s);
        counted++;
      end else if (roll < 62 && known_keys.size() > 0) begin
        kp = known_keys[$urandom_range(0, known_keys.size() - 1)];
        issue_cmd(OP_INSERT, kp.hash, kp.key, $urandom, 1'($urandom), s);
        counted++;
      end else if (roll < 88) begin
        if ($urandom_range(0, 99) < 80) s = SLOT_W'($urandom_range(0, cap - 1));
        issue_cmd(OP_READ, h, $urandom, $urandom, 1'($urandom), s);
        counted++;
      end else if (roll < 94) begin
        issue_cmd(OP_ERASE, h, $urandom, $urandom, 1'($urandom), s);
        counted++;
      end else begin
        issue_cmd(OP_NOP, h, $urandom, $urandom, 1'($urandom), s);
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_fill_and_grow();
    int n;
    key_pair_t kp;
    issue_cmd(OP_ERASE, '0, '0, '0, 1'b0, '0);
    n = 0;
    do begin
      issue_cmd(OP_INSERT, $urandom, ($urandom & 32'hFFFF_F000) | 32'(n), $urandom,
                1'($urandom), '0);
      n++;
    end while (last_status != ST_DROPPED && n < 150);
    kp = known_keys[known_keys.size() - 1];
    issue_cmd(OP_INSERT, kp.hash, kp.key, $urandom, 1'b1, '0);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd1023);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd0);
    issue_cmd(OP_ERASE, '0, '0, '0, 1'b0, '0);
    issue_cmd(OP_ERASE, '0, '0, '0, 1'b0, '0);
    issue_cmd(OP_INSERT, '1, 32'hA5A5_5A5A, '1, 1'b1, '0);
    issue_cmd(OP_READ, '0, '0, '0, 1'b0, 10'd1023);
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_opcode        <= OP_NOP;
    in_hash          <= '0;
    in_key           <= '0;
    in_value         <= '0;
    in_value_present <= 1'b0;
    in_slot          <= '0;
    cycle_count      = 0;
    steady           = 1'b0;
    mismatches       = 0;
    beats_sent       = 0;
    replies_checked  = 0;
    inserts_sent     = 0;
    reads_sent       = 0;
    erases_sent      = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    reset_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    wait_replies_drained();
    test_random_traffic();
    wait_replies_drained();
    test_fill_and_grow();

    wait_replies_drained();
    repeat (2 * MAX_CAPACITY + 64) @(posedge clk);

    $display("Covered %0d beats: %0d inserts, %0d reads, %0d erases; %0d replies checked.",
             beats_sent, inserts_sent, reads_sent, erases_sent, replies_checked);
    $display(
      "Replies: ins %0d, present %0d, drop %0d, erased %0d, empty %0d, read %0d, range %0d.",
      status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_DROPPED],
      status_seen[ST_ERASED], status_seen[ST_EMPTY], status_seen[ST_READ],
      status_seen[ST_RANGE]);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("** linear_probe_hash_cache_unit: PASSED **");
    end else begin
      $display("** linear_probe_hash_cache_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lphc_pkg.sv
src/lphc_ram.sv
src/linear_probe_hash_cache_unit.sv
tb/sv/tb.sv
